[hdl/sct_pkg.sv]
package sct_pkg;

  localparam int CMD_W    = 3;
  localparam int EVT_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;

  localparam logic [SLOT_W-1:0] RESET_SLOTS = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_ADD     = 3'd2,
    CMD_RESET   = 3'd3,
    CMD_ENABLE  = 3'd4,
    CMD_DISABLE = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_REFUSED   = 3'd1,
    STAT_NO_ENTRY  = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_DONE
  } state_t;

endpackage

[hdl/sct_req_if.sv]
interface sct_req_if;
  import sct_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [EVT_W-1:0]  event_id;
  logic [SLOT_W-1:0] slot_count;

  modport source (output valid, cmd, event_id, slot_count, input ready);
  modport sink   (input valid, cmd, event_id, slot_count, output ready);
endinterface

[hdl/sct_rsp_if.sv]
interface sct_rsp_if;
  import sct_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [INDEX_W-1:0] slot_index;
  logic [SLOT_W-1:0]  credits_left;
  logic               node_enabled;

  modport source (output valid, status, slot_index, credits_left, node_enabled, input ready);
  modport sink   (input valid, status, slot_index, credits_left, node_enabled, output ready);
endinterface

[hdl/slot_credit_table.sv]
// allocate and free scan the entries below max_credits one per cycle; the scan sets the latency
// one command at a time, next accepted once its result is registered
// rst (synchronous) and a configuration write restore credits, clear all entries, enable node
// reset clears all entries at once, no clearing pass
module slot_credit_table #(
  parameter int TABLE_SIZE = 16,
  parameter int ID_WIDTH   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sct_pkg::SLOT_W-1:0]  cfg_wdata,
  sct_req_if.sink                     req,
  sct_rsp_if.source                   rsp
);
  import sct_pkg::*;

  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

  function automatic logic [CW-1:0] clamp_size(input logic [SLOT_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > TABLE_SIZE) begin
      r = CW'(TABLE_SIZE);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [CW-1:0]         credits;
  logic [CW-1:0]         max_credits;
  logic [TABLE_SIZE-1:0] valid;
  logic                  enable_flag;
  logic [ID_WIDTH-1:0]   id_q;
  logic [CW-1:0]         idx;
  logic                  pend;
  logic [IW-1:0]         pend_idx;
  status_t               res_status;
  logic [IW-1:0]         res_index;

  logic                  out_valid;
  status_t               out_status;
  logic [INDEX_W-1:0]    out_index;
  logic [SLOT_W-1:0]     out_credits;
  logic                  out_enabled;

  logic                  mem_we;
  logic                  mem_re;
  logic [ID_WIDTH-1:0]   rd_data;

  logic [IW-1:0]         cur_idx;
  logic                  scan_end;
  logic                  free_hit;
  logic                  refused;
  logic                  out_load;
  logic [SW-1:0]         add_sum;
  logic [CW-1:0]         new_max;

  assign cur_idx  = idx[IW-1:0];
  assign scan_end = (idx == max_credits);
  assign free_hit = pend && valid[pend_idx] && (rd_data == id_q);
  assign refused  = !enable_flag || (credits == '0);
  assign add_sum  = SW'(credits) + SW'(req.slot_count);
  assign new_max  = (req.slot_count != '0) ? clamp_size(req.slot_count) : max_credits;

  sct_id_store #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (ID_WIDTH),
    .AW    (IW)
  ) u_id_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_idx),
    .wdata (id_q),
    .re    (mem_re),
    .raddr (cur_idx),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.cmd)
            CMD_ALLOC: state_next = refused ? ST_DONE : ST_ALLOC;
            CMD_FREE:  state_next = ST_FREE;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (scan_end || !valid[cur_idx]) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE: begin
        if (free_hit || (scan_end && !pend)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_ALLOC: mem_we    = !scan_end && !valid[cur_idx];
      ST_FREE:  mem_re    = !scan_end;
      ST_DONE:  out_load  = !out_valid || rsp.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_credits   <= clamp_size(RESET_SLOTS);
      credits       <= clamp_size(RESET_SLOTS);
      valid         <= '0;
      enable_flag   <= 1'b1;
      pend          <= 1'b0;
      idx           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            id_q      <= ID_WIDTH'(req.event_id);
            idx       <= '0;
            pend      <= 1'b0;
            res_index <= '0;
            case (req.cmd)
              CMD_ALLOC: res_status <= refused ? STAT_REFUSED : STAT_NO_ENTRY;
              CMD_FREE:  res_status <= STAT_NOT_FOUND;
              CMD_ADD: begin
                if (add_sum > SW'(max_credits)) begin
                  credits    <= max_credits;
                  res_status <= STAT_OVERFLOW;
                end else begin
                  credits    <= CW'(add_sum);
                  res_status <= STAT_OK;
                end
              end
              CMD_RESET: begin
                max_credits <= new_max;
                credits     <= new_max;
                valid       <= '0;
                enable_flag <= 1'b1;
                res_status  <= STAT_OK;
              end
              CMD_ENABLE: begin
                enable_flag <= 1'b1;
                res_status  <= STAT_OK;
              end
              CMD_DISABLE: begin
                enable_flag <= 1'b0;
                res_status  <= STAT_OK;
              end
              default: res_status <= STAT_OK;
            endcase
          end
        end
        ST_ALLOC: begin
          if (!scan_end) begin
            if (!valid[cur_idx]) begin
              valid[cur_idx] <= 1'b1;
              credits        <= credits - CW'(1);
              res_index      <= cur_idx;
              res_status     <= STAT_OK;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        ST_FREE: begin
          pend     <= !scan_end;
          pend_idx <= cur_idx;
          if (!scan_end) begin
            idx <= idx + CW'(1);
          end
          if (free_hit) begin
            valid[pend_idx] <= 1'b0;
            res_index       <= pend_idx;
            res_status      <= STAT_OK;
          end
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        max_credits   <= clamp_size(cfg_wdata);
        credits       <= clamp_size(cfg_wdata);
        valid         <= '0;
        enable_flag   <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status  <= res_status;
      out_index   <= INDEX_W'(res_index);
      out_credits <= SLOT_W'(credits);
      out_enabled <= enable_flag;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot_index   = out_index;
  assign rsp.credits_left = out_credits;
  assign rsp.node_enabled = out_enabled;

endmodule

[hdl/sct_id_store.sv]
module sct_id_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sim/slot_credit_table_tb.sv]
module slot_credit_table_tb;
  import sct_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_GAP = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  localparam cmd_t CMD_UNUSED_A = cmd_t'(3'd6);
  localparam cmd_t CMD_UNUSED_B = cmd_t'(3'd7);

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] slot_index;
    logic [SLOT_W-1:0]  credits_left;
    logic               node_enabled;
  } slot_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SLOT_W-1:0] cfg_wdata;

  sct_req_if req_if();
  sct_rsp_if rsp_if();

  slot_credit_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // shadow copy of the node
  logic [SLOT_W-1:0] init_slots;
  int                tbl_credits;
  int                tbl_max;
  logic [EVT_W-1:0]  tbl_ids [TABLE_DEPTH];
  bit                tbl_used [TABLE_DEPTH];
  bit                tbl_enabled;

  slot_result_t expected_results[$];
  slot_result_t want;
  int           errors;
  int           cycle_count;
  bit           req_gaps_on;
  bit           rsp_stalls_on;
  bit           hold_request;
  bit           rsp_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_slots(input logic [SLOT_W-1:0] v);
    if (v < 1) return 1;
    if (v > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(v);
  endfunction

  function automatic void restore_node();
    tbl_max = clamp_slots(init_slots);
    tbl_credits = tbl_max;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_ids[i] = '0;
    end
    tbl_enabled = 1'b1;
  endfunction

  function automatic slot_result_t predict_cmd(input cmd_t c, input logic [EVT_W-1:0] id,
                                               input logic [SLOT_W-1:0] count);
    slot_result_t r;
    bit done;
    r.status = STAT_OK;
    r.slot_index = '0;
    done = 1'b0;
    case (c)
      CMD_ALLOC: begin
        if (!tbl_enabled || tbl_credits == 0) begin
          r.status = STAT_REFUSED;
        end else begin
          r.status = STAT_NO_ENTRY;
          for (int i = 0; i < tbl_max; i++) begin
            if (!done && !tbl_used[i]) begin
              tbl_used[i] = 1'b1;
              tbl_ids[i] = id;
              tbl_credits--;
              r.slot_index = i[INDEX_W-1:0];
              r.status = STAT_OK;
              done = 1'b1;
            end
          end
        end
      end
      CMD_FREE: begin
        r.status = STAT_NOT_FOUND;
        for (int i = 0; i < tbl_max; i++) begin
          if (!done && tbl_used[i] && tbl_ids[i] == id) begin
            tbl_used[i] = 1'b0;
            r.slot_index = i[INDEX_W-1:0];
            r.status = STAT_OK;
            done = 1'b1;
          end
        end
      end
      CMD_ADD: begin
        tbl_credits = tbl_credits + int'(count);
        if (tbl_credits > tbl_max) begin
          tbl_credits = tbl_max;
          r.status = STAT_OVERFLOW;
        end
      end
      CMD_RESET: begin
        if (count != 0) tbl_max = clamp_slots(count);
        tbl_credits = tbl_max;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          tbl_used[i] = 1'b0;
          tbl_ids[i] = '0;
        end
        tbl_enabled = 1'b1;
      end
      CMD_ENABLE: tbl_enabled = 1'b1;
      CMD_DISABLE: tbl_enabled = 1'b0;
      default: ;
    endcase
    r.credits_left = tbl_credits[SLOT_W-1:0];
    r.node_enabled = tbl_enabled;
    return r;
  endfunction

  function automatic logic [EVT_W-1:0] rand_id();
    case ($urandom_range(0, 3))
      0: return EVT_W'($urandom_range(0, 7));
      1: return {{(EVT_W-3){1'b1}}, 3'($urandom_range(0, 7))};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input cmd_t c, input logic [EVT_W-1:0] id,
                          input logic [SLOT_W-1:0] count);
    int gap;
    gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= c;
    req_if.event_id <= id;
    req_if.slot_count <= count;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(predict_cmd(c, id, count));
    @(negedge clk);
  endtask

  task automatic send_random_cmd();
    int pick;
    int live;
    int k;
    cmd_t c;
    logic [EVT_W-1:0] id;
    logic [SLOT_W-1:0] count;
    pick = $urandom_range(0, 99);
    id = rand_id();
    count = SLOT_W'($urandom_range(0, 31));
    if (pick < 35) begin
      c = CMD_ALLOC;
    end else if (pick < 65) begin
      c = CMD_FREE;
      // mostly free an id that is in the table
      if (pick < 60) begin
        live = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) if (tbl_used[i]) live++;
        if (live > 0) begin
          k = $urandom_range(0, live - 1);
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_used[i]) begin
              if (k == 0) id = tbl_ids[i];
              k--;
            end
          end
        end
      end
    end else if (pick < 75) begin
      c = CMD_ADD;
      if ($urandom_range(0, 3) != 0) count = SLOT_W'($urandom_range(0, 4));
    end else if (pick < 82) begin
      c = CMD_RESET;
    end else if (pick < 89) begin
      c = CMD_ENABLE;
    end else if (pick < 95) begin
      c = CMD_DISABLE;
    end else begin
      c = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    end
    send_cmd(c, id, count);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_cmd();
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_initial_slots(input logic [SLOT_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    init_slots = v;
    restore_node();
  endtask

  task automatic test_directed();
    send_cmd(CMD_RESET, '0, 5'd2);
    send_cmd(CMD_ALLOC, 32'h0000_0000, '0);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_ALLOC, 32'h0000_0001, '0);
    send_cmd(CMD_ADD, '0, 5'd1);
    send_cmd(CMD_ALLOC, 32'h0000_0005, '0);
    send_cmd(CMD_FREE, 32'h0001_2345, '0);
    send_cmd(CMD_FREE, 32'h0000_0000, '0);
    send_cmd(CMD_ALLOC, 32'hAAAA_AAAA, '0);
    send_cmd(CMD_ADD, '0, 5'd31);
    send_cmd(CMD_ADD, '0, 5'd0);
    send_cmd(CMD_DISABLE, '0, '0);
    send_cmd(CMD_ALLOC, 32'h0000_0009, '0);
    send_cmd(CMD_FREE, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_ENABLE, '0, '0);
    send_cmd(CMD_UNUSED_A, 32'hFFFF_FFFF, 5'd31);
    send_cmd(CMD_UNUSED_B, '0, '0);
    send_cmd(CMD_RESET, '0, 5'd31);
    send_cmd(CMD_ADD, '0, 5'd16);
    send_cmd(CMD_RESET, '0, 5'd0);
    send_cmd(CMD_RESET, '0, 5'd1);
    send_cmd(CMD_ALLOC, 32'h5555_5555, '0);
    send_cmd(CMD_FREE, 32'h5555_5555, '0);
    send_cmd(CMD_FREE, 32'h5555_5555, '0);
    send_cmd(CMD_RESET, '0, 5'd16);
  endtask

  task automatic test_config_settings();
    write_initial_slots(5'd0);
    run_random(40);
    write_initial_slots(5'd31);
    run_random(40);
    write_initial_slots(5'd1);
    run_random(40);
    write_initial_slots(5'd16);
    run_random(40);
    write_initial_slots(5'($urandom_range(2, 15)));
    run_random(40);
  endtask

  task automatic test_random_traffic();
    run_random(300);
  endtask

  task automatic test_back_to_back();
    req_gaps_on = 1'b0;
    rsp_stalls_on = 1'b0;
    run_random(40);
    req_gaps_on = 1'b1;
    rsp_stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    req_gaps_on = 1'b0;
    hold_request = 1'b1;
    run_random(20);
    req_gaps_on = 1'b1;
  endtask

  // long receiver hold-off
  initial begin
    rsp_hold = 1'b0;
    forever begin
      wait (hold_request);
      @(posedge clk);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rsp_hold = 1'b0;
      hold_request = 1'b0;
    end
  end

  initial begin : rsp_sink
    int stall;
    rsp_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = rsp_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0 || rsp_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        while (rsp_hold) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      @(negedge clk);
    end
  end

  // compare every response transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d credits %0d enabled %0d",
               rsp_if.status, rsp_if.slot_index, rsp_if.credits_left, rsp_if.node_enabled);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_if.slot_index);
          errors++;
        end
        if (rsp_if.credits_left !== want.credits_left) begin
          $error("credits_left: expected %0d, got %0d", want.credits_left,
                 rsp_if.credits_left);
          errors++;
        end
        if (rsp_if.node_enabled !== want.node_enabled) begin
          $error("node_enabled: expected %0d, got %0d", want.node_enabled,
                 rsp_if.node_enabled);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** slot_credit_table: FAILED **");
      $finish;
    end
  end

  initial begin
    req_gaps_on = 1'b1;
    rsp_stalls_on = 1'b1;
    hold_request = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_ALLOC;
    req_if.event_id = '0;
    req_if.slot_count = '0;
    init_slots = RESET_SLOTS;
    restore_node();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_config_settings();
    test_random_traffic();
    test_back_to_back();
    test_backpressure();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** slot_credit_table: PASSED **");
    end else begin
      $display("** slot_credit_table: FAILED **");
    end
    $finish;
  end

endmodule
